/* hw/rtl/xcfp_pkg.sv */
// ----------------------------------------------------------------------------
// XOR-checked frame parser package
// Shared payload types for the frame parser and its result queue.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Field codes of the frame.
  localparam logic [1:0] FIELD_TYPE = 2'd0;

  // Result kinds.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes.
  localparam logic [1:0] STATUS_VALID        = 2'd0;
  localparam logic [1:0] STATUS_CKS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_BAD_COUNT    = 2'd2;
  localparam logic [1:0] STATUS_BAD_SEQ      = 2'd3;

  localparam logic [7:0] BAR_CHAR = 8'h7C;

  // One received byte of the raw frame.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } byte_item_t;

  // One result: a field byte or a frame verdict.
  typedef struct packed {
    logic              kind;
    logic [1:0]        field_index;
    logic [7:0]        field_byte;
    logic [1:0]        status;
    logic signed [31:0] sequence_number;
    logic [7:0]        computed_checksum;
    logic [2:0]        part_count;
    logic              has_payload;
    logic              last;
  } result_t;

  // Results produced by one byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage

/* hw/rtl/xcfp_parse.sv */
// ----------------------------------------------------------------------------
// Frame parser core
// Per-byte state update: delay line, field split, sequence number and XOR.
// ----------------------------------------------------------------------------
module xcfp_parse
  import xcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_item_t item,
  output parse_out_t results
);

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c1;
    logic [7:0] c0;
  } text_t;

  // Progress of the sequence number parse.
  typedef enum logic [1:0] {
    NUM_BLANKS,
    NUM_AFTER_SIGN,
    NUM_DIGITS,
    NUM_STOPPED
  } num_phase_t;

  logic [7:0]  dly0, dly1, dly0_next, dly1_next;
  logic [1:0]  pos, pos_next;
  logic [7:0]  rx, rx_next, x2, x2_next, x3, x3_next;
  logic [2:0]  bars, bars_next;
  text_t       cur, cur_next, prev, prev_next;
  logic        third_empty, third_empty_next;
  num_phase_t  nphase, nphase_next;
  logic        nneg, nneg_next;
  logic [31:0] nmag, nmag_next;
  logic        novf, novf_next;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h41 + {4'd0, v} - 8'd10);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic [1:0]  fidx;
    logic        hit;
    logic        digit;
    logic [3:0]  d;
    logic [35:0] m;
    logic [2:0]  count;
    logic        pay;
    logic [7:0]  cks;
    logic        bad;
    logic        match;
    text_t       t;
    result_t     fres, vres;

    dly0_next = dly0; dly1_next = dly1; pos_next = pos;
    rx_next = rx; x2_next = x2; x3_next = x3; bars_next = bars;
    cur_next = cur; prev_next = prev; third_empty_next = third_empty;
    nphase_next = nphase; nneg_next = nneg; nmag_next = nmag; novf_next = novf;
    c = dly0;
    fidx = bars[1:0];
    hit = 1'b0;
    digit = (c >= 8'h30) && (c <= 8'h39);
    d = c[3:0];
    m = ({4'd0, nmag} << 3) + ({4'd0, nmag} << 1) + {32'd0, d};

    unique case (pos)
      2'd0: pos_next = 2'd1;
      2'd1: begin
        dly0_next = item.data_byte;
        pos_next = 2'd2;
      end
      2'd2: begin
        dly1_next = item.data_byte;
        pos_next = 2'd3;
      end
      default: begin
        dly0_next = dly1;
        dly1_next = item.data_byte;
        rx_next = rx ^ c;
        if (c == BAR_CHAR) begin
          if (bars == 3'd1) x2_next = rx;
          if (bars == 3'd2) x3_next = rx;
          prev_next = cur;
          cur_next = '0;
          if (bars < 3'd5) bars_next = bars + 3'd1;
        end else begin
          if (bars == 3'd1) begin
            unique case (nphase)
              NUM_BLANKS: begin
                if (is_blank(c)) begin
                  nphase_next = NUM_BLANKS;
                end else if (c == 8'h2B || c == 8'h2D) begin
                  nneg_next = (c == 8'h2D);
                  nphase_next = NUM_AFTER_SIGN;
                end else if (digit) begin
                  nmag_next = {28'd0, d};
                  nphase_next = NUM_DIGITS;
                end else begin
                  novf_next = 1'b1;
                  nphase_next = NUM_STOPPED;
                end
              end
              NUM_AFTER_SIGN: begin
                if (digit) begin
                  nmag_next = {28'd0, d};
                  nphase_next = NUM_DIGITS;
                end else begin
                  novf_next = 1'b1;
                  nphase_next = NUM_STOPPED;
                end
              end
              NUM_DIGITS: begin
                if (digit) begin
                  if (!novf) begin
                    if (m > 36'h0_8000_0000) begin
                      novf_next = 1'b1;
                      nmag_next = 32'h8000_0000;
                    end else begin
                      nmag_next = m[31:0];
                    end
                  end
                end else begin
                  nphase_next = NUM_STOPPED;
                end
              end
              default: nphase_next = nphase;
            endcase
          end
          if (bars == 3'd2) third_empty_next = 1'b0;
          if (cur.len == 2'd0) cur_next.c0 = c;
          if (cur.len == 2'd1) cur_next.c1 = c;
          if (cur.len < 2'd3) cur_next.len = cur.len + 2'd1;
          hit = (bars <= 3'd3);
        end
      end
    endcase

    // The verdict reads the number state as registered: a count of three or
    // four needs at least two bars, so the sequence field is already closed.
    count = bars_next + {2'd0, (cur_next.len != 2'd0)};
    if (count > 3'd5) count = 3'd5;
    pay = (count == 3'd4) && !third_empty_next;
    cks = pay ? x3_next : x2_next;
    bad = novf || (nphase == NUM_BLANKS) || (nphase == NUM_AFTER_SIGN) ||
          (!nneg && nmag[31]);
    t = (cur_next.len != 2'd0) ? cur_next : prev_next;
    match = (t.len == 2'd2) && (t.c0 == hex_digit(cks[7:4])) &&
            (t.c1 == hex_digit(cks[3:0]));

    fres = '0;
    fres.kind = KIND_BYTE;
    fres.field_index = fidx;
    fres.field_byte = c;
    fres.last = !item.end_of_frame;

    vres = '0;
    vres.kind = KIND_VERDICT;
    vres.field_index = FIELD_TYPE;
    vres.part_count = count;
    vres.last = 1'b1;
    if (count != 3'd3 && count != 3'd4) begin
      vres.status = STATUS_BAD_COUNT;
    end else if (bad) begin
      vres.status = STATUS_BAD_SEQ;
      vres.computed_checksum = cks;
      vres.has_payload = pay;
    end else begin
      vres.status = match ? STATUS_VALID : STATUS_CKS_MISMATCH;
      vres.sequence_number = nneg ? (32'd0 - nmag) : nmag;
      vres.computed_checksum = cks;
      vres.has_payload = pay;
    end

    results = '0;
    if (take) begin
      if (hit) begin
        results.first = fres;
        results.second = vres;
        results.count = item.end_of_frame ? 2'd2 : 2'd1;
      end else if (item.end_of_frame) begin
        results.first = vres;
        results.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_frame)) begin
      pos <= 2'd0;
      dly0 <= '0;
      dly1 <= '0;
      rx <= '0;
      x2 <= '0;
      x3 <= '0;
      bars <= '0;
      cur <= '0;
      prev <= '0;
      third_empty <= 1'b1;
      nphase <= NUM_BLANKS;
      nneg <= 1'b0;
      nmag <= '0;
      novf <= 1'b0;
    end else if (take) begin
      pos <= pos_next;
      dly0 <= dly0_next;
      dly1 <= dly1_next;
      rx <= rx_next;
      x2 <= x2_next;
      x3 <= x3_next;
      bars <= bars_next;
      cur <= cur_next;
      prev <= prev_next;
      third_empty <= third_empty_next;
      nphase <= nphase_next;
      nneg <= nneg_next;
      nmag <= nmag_next;
      novf <= novf_next;
    end
  end

`ifndef SYNTHESIS
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_frame |=> pos == 2'd0 && bars == 3'd0)
    else $error("parser state not cleared after frame end");
  a_eof_verdict: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_frame |-> results.count != 2'd0)
    else $error("frame end produced no verdict");
  a_head_silent: assert property (@(posedge clk) disable iff (rst)
    take && !item.end_of_frame && pos != 2'd3 |-> results.count == 2'd0)
    else $error("result produced while delay line fills");
`endif

endmodule

/* hw/rtl/xcfp_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue: up to two results in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module xcfp_fifo
  import xcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  parse_out_t push,
  output logic       no_room,
  output logic       valid,
  input  logic       stall,
  output result_t    data
);

  result_t    mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       pop;

  assign valid   = (count != 3'd0);
  assign pop     = valid && !stall;
  assign no_room = (count > 3'd2);
  assign data    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr] <= push.first;
    if (push.count == 2'd2) mem[wptr + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + push.count;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + {1'b0, push.count} - {2'd0, pop};
    end
  end

`ifndef SYNTHESIS
  a_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue over capacity");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> !no_room)
    else $error("push into a queue without room");
  a_reset_empty: assert property (@(posedge clk) rst |=> count == 3'd0)
    else $error("queue not empty after reset");
`endif

endmodule

/* hw/rtl/xor_checked_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// XOR-checked frame parser
// Splits a bar-delimited frame into tagged field bytes and a frame verdict.
// ----------------------------------------------------------------------------
// The block takes one raw frame byte per cycle on the frame channel and can
// accept a byte in every cycle. The parser state is updated at the edge that
// accepts a byte, and the results of that byte are written into the result
// queue at that same edge; the queue offers them on the result channel after
// any older results. A byte yields at most two results (a field byte and,
// on the final byte, the verdict); the four-entry queue delivers one result
// per cycle while the result side is not stalled, and a frame of N bytes (N at
// least three) yields at most N - 2 results: up to N - 3 field bytes and one
// verdict. The frame channel stalls only while the queue holds more than two
// results, which happens only when the result side is stalled. The first frame
// byte and the last two are dropped; the rest is split on '|', bytes of the
// first four fields are tagged with their field index, and after the final
// byte a verdict transaction gives the field count, the parsed sequence
// number, the XOR checksum and a status.
module xor_checked_frame_parser_top
  import xcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       frame_valid,
  output logic       frame_stall,
  input  byte_item_t frame_data,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result_data
);

  logic       take;
  logic       no_room;
  parse_out_t parsed;

  // A transaction is taken whenever the queue can absorb two more results.
  assign frame_stall = no_room;
  assign take        = frame_valid && !no_room;

  xcfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (frame_data),
    .results (parsed)
  );

  // The queue is the result register stage and keeps the two sides apart.
  xcfp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (parsed),
    .no_room (no_room),
    .valid   (result_valid),
    .stall   (result_stall),
    .data    (result_data)
  );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds raw frames into the XOR-checked frame parser, predicts every tagged
// field byte and frame verdict, and compares each result transaction with
// the prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
  import xcfp_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_BYTES   = 700;

  typedef logic [7:0] frame_q_t[$];

  // Progress of the sequence number parse, in the style of stoi.
  typedef enum logic [1:0] {
    NUM_BLANKS,
    NUM_AFTER_SIGN,
    NUM_DIGITS,
    NUM_STOPPED
  } num_phase_t;

  // How the check field of a generated frame is written.
  typedef enum int {
    CK_GOOD,
    CK_LOWER,
    CK_WRONG,
    CK_SHORT,
    CK_LONG
  } check_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       frame_valid;
  logic       frame_stall;
  byte_item_t frame_data;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result_data;

  xor_checked_frame_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser prediction. The state mirrors the block: a two-byte delay line that
  // hides the last two bytes of a frame, the running XOR with snapshots taken
  // at the second and third bar, the first two characters of the current and
  // previous field, and the sequence number parse.
  // --------------------------------------------------------------------------
  logic [7:0]  hold0, hold1;
  logic [1:0]  byte_pos;
  logic [7:0]  run_xor, xor_bar2, xor_bar3;
  logic [2:0]  bar_cnt;
  logic [17:0] cur_text, prev_text;
  logic        third_empty;
  num_phase_t  num_phase;
  logic        num_neg;
  logic [31:0] num_mag;
  logic        num_bad;

  result_t predicted_results[$];

  function automatic void clear_parser();
    hold0       = '0;
    hold1       = '0;
    byte_pos    = '0;
    run_xor     = '0;
    xor_bar2    = '0;
    xor_bar3    = '0;
    bar_cnt     = '0;
    cur_text    = '0;
    prev_text   = '0;
    third_empty = 1'b1;
    num_phase   = NUM_BLANKS;
    num_neg     = 1'b0;
    num_mag     = '0;
    num_bad     = 1'b0;
  endfunction

  function automatic void seq_take(input logic [7:0] c);
    logic        is_digit;
    logic        is_blank;
    logic [35:0] prod;
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    is_blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    case (num_phase)
      NUM_BLANKS: begin
        if (c == "+" || c == "-") begin
          num_neg   = (c == "-");
          num_phase = NUM_AFTER_SIGN;
        end else if (is_digit) begin
          num_mag   = {28'd0, c[3:0]};
          num_phase = NUM_DIGITS;
        end else if (!is_blank) begin
          num_bad   = 1'b1;
          num_phase = NUM_STOPPED;
        end
      end
      NUM_AFTER_SIGN: begin
        if (is_digit) begin
          num_mag   = {28'd0, c[3:0]};
          num_phase = NUM_DIGITS;
        end else begin
          num_bad   = 1'b1;
          num_phase = NUM_STOPPED;
        end
      end
      NUM_DIGITS: begin
        if (!is_digit) begin
          num_phase = NUM_STOPPED;
        end else if (!num_bad) begin
          // The magnitude saturates at the magnitude of the negative limit.
          prod = {4'd0, num_mag} * 36'd10 + {32'd0, c[3:0]};
          if (prod > 36'h080000000) begin
            num_bad = 1'b1;
            prod    = 36'h080000000;
          end
          num_mag = prod[31:0];
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [17:0] text_append(input logic [17:0] t, input logic [7:0] c);
    if (t[17:16] == 2'd0) t[7:0] = c;
    if (t[17:16] == 2'd1) t[15:8] = c;
    if (t[17:16] != 2'd3) t[17:16] = t[17:16] + 2'd1;
    return t;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h41 + {4'd0, v} - 8'd10;
  endfunction

  // One byte of the body; returns 1 when it streams out as a field byte.
  function automatic bit take_body_byte(input logic [7:0] c);
    if (c == BAR_CHAR) begin
      if (bar_cnt == 3'd1) xor_bar2 = run_xor;
      if (bar_cnt == 3'd2) xor_bar3 = run_xor;
      prev_text = cur_text;
      cur_text  = '0;
      if (bar_cnt < 3'd5) bar_cnt = bar_cnt + 3'd1;
      run_xor = run_xor ^ c;
      return 1'b0;
    end
    if (bar_cnt == 3'd1) seq_take(c);
    if (bar_cnt == 3'd2) third_empty = 1'b0;
    cur_text = text_append(cur_text, c);
    run_xor  = run_xor ^ c;
    return bar_cnt <= 3'd3;
  endfunction

  function automatic void parse_frame_byte(input byte_item_t item);
    result_t     outs [2];
    int          n;
    logic [7:0]  c;
    logic [1:0]  fidx;
    logic [3:0]  count;
    logic        pay;
    logic        bad;
    logic        match;
    logic [7:0]  cks;
    logic [17:0] ck_text;
    n = 0;
    case (byte_pos)
      2'd0: byte_pos = 2'd1;
      2'd1: begin
        hold0    = item.data_byte;
        byte_pos = 2'd2;
      end
      2'd2: begin
        hold1    = item.data_byte;
        byte_pos = 2'd3;
      end
      default: begin
        c     = hold0;
        fidx  = bar_cnt[1:0];
        hold0 = hold1;
        hold1 = item.data_byte;
        if (take_body_byte(c)) begin
          outs[n]             = '0;
          outs[n].kind        = KIND_BYTE;
          outs[n].field_index = fidx;
          outs[n].field_byte  = c;
          n++;
        end
      end
    endcase

    if (item.end_of_frame) begin
      outs[n]      = '0;
      outs[n].kind = KIND_VERDICT;
      // A trailing empty field is not counted, as with getline.
      count = {1'b0, bar_cnt} + ((cur_text[17:16] != 2'd0) ? 4'd1 : 4'd0);
      if (count > 4'd5) count = 4'd5;
      outs[n].part_count = count[2:0];
      if (count != 4'd3 && count != 4'd4) begin
        outs[n].status = STATUS_BAD_COUNT;
      end else begin
        pay = (count == 4'd4) && !third_empty;
        cks = pay ? xor_bar3 : xor_bar2;
        bad = num_bad || num_phase == NUM_BLANKS || num_phase == NUM_AFTER_SIGN ||
              (!num_neg && num_mag > 32'h7FFFFFFF);
        outs[n].computed_checksum = cks;
        outs[n].has_payload       = pay;
        if (bad) begin
          outs[n].status = STATUS_BAD_SEQ;
        end else begin
          ck_text = (cur_text[17:16] != 2'd0) ? cur_text : prev_text;
          match   = ck_text[17:16] == 2'd2 && ck_text[7:0] == hex_char(cks[7:4]) &&
                    ck_text[15:8] == hex_char(cks[3:0]);
          outs[n].status          = match ? STATUS_VALID : STATUS_CKS_MISMATCH;
          outs[n].sequence_number = num_neg ? 32'd0 - num_mag : num_mag;
        end
      end
      n++;
      clear_parser();
    end

    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      predicted_results = {predicted_results, outs[i]};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Every accepted result transaction is matched against the
  // oldest predicted one, field by field.
  // --------------------------------------------------------------------------
  int errors = 0;

  task automatic report(input string msg);
    if (errors < 50) $display("%0t tb mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_results.size() == 0) begin
        report("result transaction arrived with none predicted");
      end else begin
        want = predicted_results.pop_front();
        check_field("kind", result_data.kind, want.kind);
        check_field("field_index", result_data.field_index, want.field_index);
        check_field("field_byte", result_data.field_byte, want.field_byte);
        check_field("status", result_data.status, want.status);
        check_field("sequence_number", result_data.sequence_number, want.sequence_number);
        check_field("computed_checksum", result_data.computed_checksum,
                    want.computed_checksum);
        check_field("part_count", result_data.part_count, want.part_count);
        check_field("has_payload", result_data.has_payload, want.has_payload);
        check_field("last", result_data.last, want.last);
      end
    end
  end

  // The run is stopped when neither channel moves a transaction for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((frame_valid && !frame_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stalls: runs of open and stalled cycles of random length.
  // --------------------------------------------------------------------------
  bit rx_stall_en = 1'b1;
  int rx_left     = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left      <= $urandom_range(1, 12);
      result_stall <= rx_stall_en && ($urandom_range(0, 2) == 0);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Bytes go out in bursts of random length with random gaps between
  // them, so gaps land anywhere inside a frame, the final byte included.
  // --------------------------------------------------------------------------
  bit       tx_idle_en = 1'b1;
  int       burst_left = 0;
  int       bytes_sent = 0;
  frame_q_t frame_buf;

  task automatic send_byte(input logic [7:0] value, input logic eof);
    byte_item_t item;
    int         gap;
    item.data_byte    = value;
    item.end_of_frame = eof;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = tx_idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        frame_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    frame_valid <= 1'b1;
    frame_data  <= item;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    parse_frame_byte(item);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Holds the sender off until every predicted result has been delivered.
  task automatic wait_for_results();
    frame_valid <= 1'b0;
    do @(posedge clk); while (predicted_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Frame generation.
  // --------------------------------------------------------------------------
  function automatic frame_q_t str_bytes(input string s);
    frame_q_t q;
    q = {};
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    return q;
  endfunction

  function automatic frame_q_t rand_field(input int max_len, input bit printable);
    frame_q_t   q;
    logic [7:0] b;
    q = {};
    repeat ($urandom_range(0, max_len)) begin
      do b = printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
      while (b == BAR_CHAR);
      q = {q, b};
    end
    return q;
  endfunction

  // Sequence number text: mostly plain decimals, plus blanks and signs,
  // range limits, trailing junk, missing digits and raw bytes.
  function automatic frame_q_t gen_seq();
    frame_q_t   q;
    string      limits [7];
    string      broken [5];
    int         sel;
    logic [7:0] blank;
    limits = '{"2147483647", "-2147483648", "2147483648", "-2147483649",
               "99999999999", "-0", "0000000000012"};
    broken = '{"", "-", "+", "AB", "+x"};
    sel = $urandom_range(0, 11);
    q = {};
    if (sel == 6 || sel == 7) begin
      repeat ($urandom_range(1, 3)) begin
        blank = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
        q = {q, blank};
      end
    end
    case (sel)
      4:       q = {q, str_bytes($sformatf("-%0d", $urandom_range(0, 99999)))};
      5:       q = {q, str_bytes(limits[$urandom_range(0, 6)])};
      6:       q = {q, str_bytes($sformatf("+%0d", $urandom()))};
      8:       q = {q, str_bytes($sformatf("%0dx7", $urandom_range(0, 999)))};
      9:       q = {q, str_bytes(broken[$urandom_range(0, 4)])};
      10:      q = rand_field(4, 1'b0);
      11:      q = {q, str_bytes($sformatf("%0d%0d", $urandom(), $urandom()))};
      default: q = {q, str_bytes($sformatf("%0d", $urandom_range(0, 99999)))};
    endcase
    return q;
  endfunction

  // Builds lead byte, "type|seq[|payload]|check", an optional extra bar and
  // field, and two trailing bytes into frame_buf.
  function automatic void assemble_frame(input frame_q_t typ, input frame_q_t seq,
                                         input frame_q_t pay, input bit four,
                                         input int tail, input check_t ck);
    logic [7:0] x;
    logic [7:0] flip;
    string      hx;
    frame_buf = {8'($urandom_range(0, 255))};
    x = BAR_CHAR;
    foreach (typ[i]) x = x ^ typ[i];
    foreach (seq[i]) x = x ^ seq[i];
    frame_buf = {frame_buf, typ, BAR_CHAR, seq};
    if (four) begin
      frame_buf = {frame_buf, BAR_CHAR, pay};
      if (pay.size() != 0) begin
        x = x ^ BAR_CHAR;
        foreach (pay[i]) x = x ^ pay[i];
      end
    end
    frame_buf = {frame_buf, BAR_CHAR};
    hx = $sformatf("%02X", x);
    case (ck)
      CK_LOWER: hx = hx.tolower();
      CK_WRONG: begin
        flip = 8'($urandom_range(1, 255));
        hx   = $sformatf("%02X", x ^ flip);
      end
      CK_SHORT: hx = hx.substr(0, 0);
      CK_LONG:  hx = {hx, "0"};
      default: begin
      end
    endcase
    frame_buf = {frame_buf, str_bytes(hx)};
    if (tail != 0) frame_buf = {frame_buf, BAR_CHAR};
    if (tail == 2) frame_buf = {frame_buf, rand_field(3, 1'b1)};
    frame_buf = {frame_buf, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Frames of one, two and three bytes leave no body and so no fields.
  task automatic test_short_frames();
    frame_buf = {8'h24};
    send_frame();
    frame_buf = {8'h00, 8'hFF};
    send_frame();
    frame_buf = {BAR_CHAR, 8'h0D, 8'h0A};
    send_frame();
  endtask

  // Four fields with extreme byte values and the most negative sequence number.
  task automatic test_extreme_frame();
    frame_q_t typ;
    frame_q_t pay;
    typ = {8'h00, 8'hFF};
    pay = {8'hFF, 8'h80, 8'h01};
    assemble_frame(typ, str_bytes("-2147483648"), pay, 1'b1, 0, CK_GOOD);
    send_frame();
  endtask

  // An out-of-range sequence number behind a blank, with an empty payload.
  task automatic test_bad_sequence();
    frame_q_t none;
    none = {};
    assemble_frame(str_bytes("T"), str_bytes(" 2147483648"), none, 1'b1, 0, CK_GOOD);
    send_frame();
  endtask

  // Five fields: a wrong count, and the fifth field streams no bytes out.
  task automatic test_field_count();
    frame_buf = {str_bytes("xA|+|0|00|7"), 8'h0D, 8'h0A};
    send_frame();
  endtask

  task automatic send_random_frame();
    check_t     ck;
    int         shape;
    int         tail;
    logic [7:0] b;
    shape = $urandom_range(0, 9);
    case ($urandom_range(0, 9))
      6:       ck = CK_LOWER;
      7:       ck = CK_WRONG;
      8:       ck = CK_SHORT;
      9:       ck = CK_LONG;
      default: ck = CK_GOOD;
    endcase
    tail = ($urandom_range(0, 7) == 0) ? 1 : (($urandom_range(0, 7) == 0) ? 2 : 0);
    if (shape < 8) begin
      assemble_frame(rand_field(3, shape < 5), gen_seq(), rand_field(5, shape < 5),
                     1'($urandom_range(0, 1)), tail, ck);
    end else begin
      // Noise: random bytes with many bars.
      frame_buf = {};
      repeat ($urandom_range(1, 14)) begin
        b = ($urandom_range(0, 3) == 0) ? BAR_CHAR : 8'($urandom_range(0, 255));
        frame_buf = {frame_buf, b};
      end
    end
    send_frame();
  endtask

  // Mostly well-formed frames with random content; the idling mode changes
  // every dozen frames, and once the sender drains the block mid-run.
  task automatic test_random_frames();
    int start;
    int frames;
    start  = bytes_sent;
    frames = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (frames % 12 == 0) begin
        tx_idle_en  = $urandom_range(0, 3) != 0;
        rx_stall_en = $urandom_range(0, 3) != 0;
      end
      if (frames == 30) wait_for_results();
      send_random_frame();
      frames++;
    end
  endtask

  initial begin
    rst         <= 1'b1;
    frame_valid <= 1'b0;
    frame_data  <= '0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_short_frames();
    test_extreme_frame();
    wait_for_results();
    test_bad_sequence();
    test_field_count();
    test_random_frames();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
